>>> rtl/wsfd_pkg.sv
`default_nettype none
package wsfd_pkg;

	// parser phases
	localparam logic [2:0] PH_HDR1    = 3'd0;
	localparam logic [2:0] PH_HDR2    = 3'd1;
	localparam logic [2:0] PH_EXTLEN  = 3'd2;
	localparam logic [2:0] PH_KEY     = 3'd3;
	localparam logic [2:0] PH_PAYLOAD = 3'd4;
	localparam logic [2:0] PH_DROP    = 3'd5;

	// result kinds
	localparam logic [1:0] KIND_HEADER  = 2'd0;
	localparam logic [1:0] KIND_PAYLOAD = 2'd1;
	localparam logic [1:0] KIND_ERROR   = 2'd2;

	// opcode classes
	localparam logic [1:0] ACT_FORWARD = 2'd0;
	localparam logic [1:0] ACT_CLOSE   = 2'd1;
	localparam logic [1:0] ACT_REJECT  = 2'd2;
	localparam logic [1:0] ACT_UNKNOWN = 2'd3;

	localparam logic [6:0] LEN_CODE_16 = 7'd126;
	localparam logic [6:0] LEN_CODE_64 = 7'd127;

	localparam logic [3:0] EXT_BYTES_16 = 4'd2;
	localparam logic [3:0] EXT_BYTES_64 = 4'd8;
	localparam logic [3:0] KEY_BYTES    = 4'd4;

	localparam logic [3:0] OP_CLOSE = 4'd8;
	localparam logic [3:0] OP_PING  = 4'd9;
	localparam logic [3:0] OP_PONG  = 4'd10;

	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  action;
		logic [3:0]  opcode;
		logic        fin;
		logic [63:0] payload_length;
		logic [7:0]  data;
		logic        last;
	} result_t;

	function automatic logic [1:0] classify(input logic [3:0] op);
		logic [1:0] act;
		if (op <= 4'd2)
			act = ACT_FORWARD;
		else if (op == OP_CLOSE)
			act = ACT_CLOSE;
		else if (op == OP_PING || op == OP_PONG)
			act = ACT_REJECT;
		else
			act = ACT_UNKNOWN;
		return act;
	endfunction

endpackage
`default_nettype wire

>>> rtl/wsfd_parser.sv
`default_nettype none
module wsfd_parser (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [7:0]        in_byte,
	input  wire logic              room,
	output logic                   res_load,
	output wsfd_pkg::result_t      res
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        go;

	logic [2:0]  phase_q, phase_d;
	logic [3:0]  ext_left_q, ext_left_d;
	logic [63:0] len_q, len_d;
	logic [31:0] key_q, key_d;
	logic [1:0]  kidx_q, kidx_d;
	logic [63:0] remain_q, remain_d;
	logic [3:0]  op_q, op_d;
	logic        fin_q, fin_d;
	logic        halted_q, halted_d;
	logic        emit;

	assign go       = valid_s1 & room;
	assign in_ready = ~valid_s1 | room;
	assign res_load = go & emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= in_byte;
		end
	end

	always_comb begin
		logic [1:0] act;
		logic [7:0] kb;
		logic       fin_last;
		phase_d    = phase_q;
		ext_left_d = ext_left_q;
		len_d      = len_q;
		key_d      = key_q;
		kidx_d     = kidx_q;
		remain_d   = remain_q;
		op_d       = op_q;
		fin_d      = fin_q;
		halted_d   = halted_q;
		emit       = 1'b0;
		act        = wsfd_pkg::classify(op_q);
		kb         = key_q[5'd31 - {kidx_q, 3'b000} -: 8];
		fin_last   = (remain_q == 64'd1);
		res.kind           = wsfd_pkg::KIND_ERROR;
		res.action         = wsfd_pkg::ACT_REJECT;
		res.opcode         = op_q;
		res.fin            = fin_q;
		res.payload_length = 64'd0;
		res.data           = 8'd0;
		res.last           = 1'b0;
		if (!halted_q) begin
			case (phase_q)
				wsfd_pkg::PH_HDR1: begin
					fin_d      = byte_s1[7];
					op_d       = byte_s1[3:0];
					len_d      = 64'd0;
					key_d      = 32'd0;
					res.opcode = byte_s1[3:0];
					res.fin    = byte_s1[7];
					if (byte_s1[6:4] != 3'b000) begin
						halted_d = 1'b1;
						emit     = 1'b1;
					end else begin
						phase_d = wsfd_pkg::PH_HDR2;
					end
				end
				wsfd_pkg::PH_HDR2: begin
					if (!byte_s1[7]) begin
						halted_d = 1'b1;
						emit     = 1'b1;
					end else if (byte_s1[6:0] == wsfd_pkg::LEN_CODE_16 ||
							byte_s1[6:0] == wsfd_pkg::LEN_CODE_64) begin
						len_d      = 64'd0;
						ext_left_d = (byte_s1[6:0] == wsfd_pkg::LEN_CODE_16) ?
							wsfd_pkg::EXT_BYTES_16 : wsfd_pkg::EXT_BYTES_64;
						phase_d    = wsfd_pkg::PH_EXTLEN;
					end else begin
						len_d      = {57'd0, byte_s1[6:0]};
						ext_left_d = wsfd_pkg::KEY_BYTES;
						phase_d    = wsfd_pkg::PH_KEY;
					end
				end
				wsfd_pkg::PH_EXTLEN: begin
					len_d = {len_q[55:0], byte_s1};
					if (ext_left_q == 4'd1) begin
						ext_left_d = wsfd_pkg::KEY_BYTES;
						phase_d    = wsfd_pkg::PH_KEY;
					end else begin
						ext_left_d = ext_left_q - 4'd1;
					end
				end
				wsfd_pkg::PH_KEY: begin
					key_d      = {key_q[23:0], byte_s1};
					ext_left_d = ext_left_q - 4'd1;
					if (ext_left_q == 4'd1) begin
						// header complete
						remain_d           = len_q;
						kidx_d             = 2'd0;
						emit               = 1'b1;
						res.payload_length = len_q;
						if (act == wsfd_pkg::ACT_REJECT) begin
							halted_d = 1'b1;
						end else if (len_q == 64'd0) begin
							if (act == wsfd_pkg::ACT_CLOSE)
								halted_d = 1'b1;
							phase_d    = wsfd_pkg::PH_HDR1;
							res.kind   = wsfd_pkg::KIND_HEADER;
							res.action = act;
							res.last   = 1'b1;
						end else begin
							phase_d    = (act == wsfd_pkg::ACT_UNKNOWN) ?
								wsfd_pkg::PH_DROP : wsfd_pkg::PH_PAYLOAD;
							res.kind   = wsfd_pkg::KIND_HEADER;
							res.action = act;
						end
					end
				end
				wsfd_pkg::PH_PAYLOAD: begin
					kidx_d             = kidx_q + 2'd1;
					remain_d           = remain_q - 64'd1;
					emit               = 1'b1;
					res.kind           = wsfd_pkg::KIND_PAYLOAD;
					res.action         = act;
					res.payload_length = len_q;
					res.data           = byte_s1 ^ kb;
					res.last           = fin_last;
					if (fin_last) begin
						if (act == wsfd_pkg::ACT_CLOSE)
							halted_d = 1'b1;
						phase_d = wsfd_pkg::PH_HDR1;
					end
				end
				wsfd_pkg::PH_DROP: begin
					remain_d = remain_q - 64'd1;
					if (fin_last)
						phase_d = wsfd_pkg::PH_HDR1;
				end
				default: begin
					phase_d = wsfd_pkg::PH_HDR1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= wsfd_pkg::PH_HDR1;
			ext_left_q <= 4'd0;
			len_q      <= 64'd0;
			key_q      <= 32'd0;
			kidx_q     <= 2'd0;
			remain_q   <= 64'd0;
			op_q       <= 4'd0;
			fin_q      <= 1'b0;
			halted_q   <= 1'b0;
		end else if (go) begin
			phase_q    <= phase_d;
			ext_left_q <= ext_left_d;
			len_q      <= len_d;
			key_q      <= key_d;
			kidx_q     <= kidx_d;
			remain_q   <= remain_d;
			op_q       <= op_d;
			fin_q      <= fin_d;
			halted_q   <= halted_d;
		end
	end

endmodule
`default_nettype wire

>>> rtl/wsfd_out_reg.sv
`default_nettype none
module wsfd_out_reg (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              res_load,
	input  wire wsfd_pkg::result_t res,
	output logic                   room,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output wsfd_pkg::result_t      res_q
);

	logic out_valid_q;

	assign room      = ~out_valid_q | out_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (room) begin
			out_valid_q <= res_load;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res;
		end
	end

endmodule
`default_nettype wire

>>> rtl/websocket_frame_deframer.sv
// WebSocket receive-side frame deframer.
// Input channel: in_valid/in_ready/in_byte, one received stream byte per beat.
// Output channel: out_valid/out_ready with kind, action, opcode, fin,
// payload_length, data and last. A beat is a header result (last header
// byte), an unmasked payload byte, or a protocol error; most header bytes
// and dropped payload bytes give no output beat.
// Throughput: one input byte per cycle while the receiver keeps taking beats.
// Path: each accepted byte is held in the input register, and its result is
// then loaded into the result register, from which the receiver takes it.
// Reset: arst_n clears the input and output valids and returns the parser to
// waiting for the first header byte with all frame state cleared.
// Stall: while a result waits and out_ready is low, the input register
// holds one more byte and then in_ready drops; nothing is lost.
// After a protocol error, or once a close frame completes, every later byte
// is taken and discarded until reset.
`default_nettype none
module websocket_frame_deframer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  in_byte,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       kind,
	output logic [1:0]       action,
	output logic [3:0]       opcode,
	output logic             fin,
	output logic [63:0]      payload_length,
	output logic [7:0]       data,
	output logic             last
);

	logic              room;
	logic              res_load;
	wsfd_pkg::result_t res;
	wsfd_pkg::result_t res_q;

	// parse one byte per cycle, while the output has room, against the frame state
	wsfd_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_byte  (in_byte),
		.room     (room),
		.res_load (res_load),
		.res      (res)
	);

	// hold the result until the receiver takes it
	wsfd_out_reg u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.res_load  (res_load),
		.res       (res),
		.room      (room),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res_q     (res_q)
	);

	assign kind           = res_q.kind;
	assign action         = res_q.action;
	assign opcode         = res_q.opcode;
	assign fin            = res_q.fin;
	assign payload_length = res_q.payload_length;
	assign data           = res_q.data;
	assign last           = res_q.last;

endmodule
`default_nettype wire
